[sv/gbn_pkg.sv]
// ----------------------------------------------------------------------------
// gbn_pkg: Go-Back-N window control shared types and constants
// Event and result words, sequencer control word and its program.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int SEQ_W   = 3;
    localparam logic [SEQ_W-1:0] SEQ_MAX = 3'd7;
    localparam logic [2:0] WINDOW_LIMIT_RESET = 3'd7;

    // event codes
    localparam logic [1:0] CMD_PACKET  = 2'd0;
    localparam logic [1:0] CMD_LINK    = 2'd1;
    localparam logic [1:0] CMD_FRAME   = 2'd2;
    localparam logic [1:0] CMD_TIMEOUT = 2'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    // result action codes
    localparam logic [2:0] ACT_SEND_DATA  = 3'd0;
    localparam logic [2:0] ACT_SEND_ACK   = 3'd1;
    localparam logic [2:0] ACT_DELIVER    = 3'd2;
    localparam logic [2:0] ACT_STOP_TIMER = 3'd3;
    localparam logic [2:0] ACT_STATUS     = 3'd4;

    typedef struct packed {
        logic [1:0]       command;
        logic             frame_kind;
        logic [SEQ_W-1:0] frame_seq;
        logic [SEQ_W-1:0] cum_ack;
        logic             frame_good;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [SEQ_W-1:0] out_seq;
        logic [SEQ_W-1:0] out_ack;
        logic             network_enable;
        logic             last;
    } out_item_t;

    // sequence field source of an emitted word
    localparam logic [1:0] SEL_ZERO   = 2'd0;
    localparam logic [1:0] SEL_NEXT   = 2'd1;
    localparam logic [1:0] SEL_BASE   = 2'd2;
    localparam logic [1:0] SEL_CURSOR = 2'd3;

    // jump conditions
    localparam logic [3:0] COND_NONE      = 4'd0;
    localparam logic [3:0] COND_ALWAYS    = 4'd1;
    localparam logic [3:0] COND_NOT_FIRE  = 4'd2;
    localparam logic [3:0] COND_CMD_PKT   = 4'd3;
    localparam logic [3:0] COND_CMD_LINK  = 4'd4;
    localparam logic [3:0] COND_CMD_FRAME = 4'd5;
    localparam logic [3:0] COND_LOOP_DONE = 4'd6;
    localparam logic [3:0] COND_WIN_FULL  = 4'd7;
    localparam logic [3:0] COND_NOT_GOOD  = 4'd8;
    localparam logic [3:0] COND_KIND_ACK  = 4'd9;
    localparam logic [3:0] COND_SEQ_MISS  = 4'd10;
    localparam logic [3:0] COND_NO_FREE   = 4'd11;

    typedef struct packed {
        logic       emit;
        logic [2:0] act;
        logic [1:0] seq_sel;
        logic       seq_fseq;
        logic       ack_lio;
        logic       count_inc;
        logic       count_dec;
        logic       next_inc;
        logic       base_inc;
        logic       rexp_inc;
        logic       link_set;
        logic       link_clr;
        logic       cur_load;
        logic       cur_step;
        logic [3:0] cond;
        logic [4:0] target;
    } uword_t;

    // program steps
    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_DISP_PKT = 5'd1;
    localparam logic [4:0] ST_DISP_LNK = 5'd2;
    localparam logic [4:0] ST_DISP_FRM = 5'd3;
    localparam logic [4:0] ST_TO_LOAD  = 5'd4;
    localparam logic [4:0] ST_TO_LOOP  = 5'd5;
    localparam logic [4:0] ST_TO_SEND  = 5'd6;
    localparam logic [4:0] ST_PKT      = 5'd7;
    localparam logic [4:0] ST_PKT_SEND = 5'd8;
    localparam logic [4:0] ST_LINK     = 5'd9;
    localparam logic [4:0] ST_FRAME    = 5'd10;
    localparam logic [4:0] ST_KIND     = 5'd11;
    localparam logic [4:0] ST_SEQ_CHK  = 5'd12;
    localparam logic [4:0] ST_DELIVER  = 5'd13;
    localparam logic [4:0] ST_ACK      = 5'd14;
    localparam logic [4:0] ST_REL_CHK  = 5'd15;
    localparam logic [4:0] ST_RELEASE  = 5'd16;
    localparam logic [4:0] ST_STATUS   = 5'd17;

    function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] s);
        return (s == SEQ_MAX) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SEQ_W-1:0] seq_prev(input logic [SEQ_W-1:0] s);
        return (s == '0) ? SEQ_MAX : s - 1'b1;
    endfunction

    // circular interval [lo, hi)
    function automatic logic in_window(input logic [SEQ_W-1:0] lo,
                                       input logic [SEQ_W-1:0] x,
                                       input logic [SEQ_W-1:0] hi);
        return (lo <= x && x < hi) || (hi < lo && lo <= x) || (x < hi && hi < lo);
    endfunction

    function automatic uword_t ucode(input logic [4:0] step);
        uword_t w;
        w = '0;
        unique case (step)
            ST_IDLE:     begin w.cond = COND_NOT_FIRE;  w.target = ST_IDLE;     end
            ST_DISP_PKT: begin w.cond = COND_CMD_PKT;   w.target = ST_PKT;      end
            ST_DISP_LNK: begin w.cond = COND_CMD_LINK;  w.target = ST_LINK;     end
            ST_DISP_FRM: begin w.cond = COND_CMD_FRAME; w.target = ST_FRAME;    end
            ST_TO_LOAD:  begin w.cur_load = 1'b1; end
            ST_TO_LOOP:  begin w.cond = COND_LOOP_DONE; w.target = ST_STATUS;   end
            ST_TO_SEND:
            begin
                w.emit = 1'b1;  w.act = ACT_SEND_DATA; w.seq_sel = SEL_CURSOR;
                w.ack_lio = 1'b1; w.cur_step = 1'b1; w.link_clr = 1'b1;
                w.cond = COND_ALWAYS; w.target = ST_TO_LOOP;
            end
            ST_PKT:      begin w.cond = COND_WIN_FULL;  w.target = ST_STATUS;   end
            ST_PKT_SEND:
            begin
                w.emit = 1'b1;  w.act = ACT_SEND_DATA; w.seq_sel = SEL_NEXT;
                w.ack_lio = 1'b1; w.count_inc = 1'b1; w.next_inc = 1'b1;
                w.link_clr = 1'b1; w.cond = COND_ALWAYS; w.target = ST_STATUS;
            end
            ST_LINK:
            begin
                w.link_set = 1'b1; w.cond = COND_ALWAYS; w.target = ST_STATUS;
            end
            ST_FRAME:    begin w.cond = COND_NOT_GOOD;  w.target = ST_STATUS;   end
            ST_KIND:     begin w.cond = COND_KIND_ACK;  w.target = ST_REL_CHK;  end
            ST_SEQ_CHK:  begin w.cond = COND_SEQ_MISS;  w.target = ST_ACK;      end
            ST_DELIVER:
            begin
                w.emit = 1'b1; w.act = ACT_DELIVER; w.seq_fseq = 1'b1;
                w.rexp_inc = 1'b1;
            end
            ST_ACK:
            begin
                w.emit = 1'b1; w.act = ACT_SEND_ACK; w.ack_lio = 1'b1;
                w.link_clr = 1'b1;
            end
            ST_REL_CHK:  begin w.cond = COND_NO_FREE;   w.target = ST_STATUS;   end
            ST_RELEASE:
            begin
                w.emit = 1'b1; w.act = ACT_STOP_TIMER; w.seq_sel = SEL_BASE;
                w.count_dec = 1'b1; w.base_inc = 1'b1;
                w.cond = COND_ALWAYS; w.target = ST_REL_CHK;
            end
            ST_STATUS:
            begin
                w.emit = 1'b1; w.act = ACT_STATUS;
                w.cond = COND_ALWAYS; w.target = ST_IDLE;
            end
            default:     begin w.cond = COND_ALWAYS;    w.target = ST_IDLE;     end
        endcase
        return w;
    endfunction

endpackage

[sv/go_back_n_window_control.sv]
// ----------------------------------------------------------------------------
// go_back_n_window_control: Go-Back-N sliding-window control, 3-bit sequence
// Microcoded sequencer that turns link events into send, ack, deliver,
// stop-timer and status words.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one event word (in_data). in_ready is high only
//   while the sequencer sits in its idle step; an accepted event runs a short
//   program from a control-word table, one step per cycle unless the output stalls.
//   out_valid/out_ready carry result words (out_data), one per emitting step;
//   every event ends with a status word marked by last.
//   cfg_wr_en/cfg_wr_data write window_limit (reset value 7).
//   Reset clears base, next-to-send, count and expected sequence, the link-ready flag and the output valid.
//   When the receiver stalls, the output word holds and the sequencer waits
//   at its next emitting step; a finished status word may wait while the
//   next event is accepted.
module go_back_n_window_control
    import gbn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_wr_en,
    input  logic [2:0] cfg_wr_data
);

    logic [4:0]       pc_reg, pc_next;
    in_item_t         ev_reg;
    logic [2:0]       limit_reg;
    logic [SEQ_W-1:0] base_reg, base_next;
    logic [SEQ_W-1:0] nts_reg, nts_next;
    logic [2:0]       count_reg, count_next;
    logic [SEQ_W-1:0] rexp_reg, rexp_next;
    logic             link_reg, link_next;
    logic [SEQ_W-1:0] cur_reg, cur_next;
    logic [2:0]       left_reg, left_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    uword_t           uw;
    logic             in_fire;
    logic             cond_hit;
    logic             stall;
    logic             go;
    logic [SEQ_W-1:0] seq_val;

    assign uw       = ucode(pc_reg);
    assign in_ready = (pc_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign stall    = uw.emit && out_valid_reg && !out_ready;
    assign go       = !stall;

    always_comb
    begin
        unique case (uw.cond)
            COND_NONE:      cond_hit = 1'b0;
            COND_ALWAYS:    cond_hit = 1'b1;
            COND_NOT_FIRE:  cond_hit = !in_fire;
            COND_CMD_PKT:   cond_hit = (ev_reg.command == CMD_PACKET);
            COND_CMD_LINK:  cond_hit = (ev_reg.command == CMD_LINK);
            COND_CMD_FRAME: cond_hit = (ev_reg.command == CMD_FRAME);
            COND_LOOP_DONE: cond_hit = (left_reg == '0);
            COND_WIN_FULL:  cond_hit = !(count_reg < limit_reg);
            COND_NOT_GOOD:  cond_hit = !ev_reg.frame_good;
            COND_KIND_ACK:  cond_hit = (ev_reg.frame_kind == KIND_ACK);
            COND_SEQ_MISS:  cond_hit = (ev_reg.frame_seq != rexp_reg);
            COND_NO_FREE:   cond_hit = !((count_reg != '0) &&
                                         in_window(base_reg, ev_reg.cum_ack, nts_reg));
            default:        cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (uw.seq_sel)
            SEL_NEXT:   seq_val = nts_reg;
            SEL_BASE:   seq_val = base_reg;
            SEL_CURSOR: seq_val = cur_reg;
            SEL_ZERO:   seq_val = uw.seq_fseq ? ev_reg.frame_seq : '0;
        endcase
    end

    always_comb
    begin
        pc_next        = pc_reg;
        base_next      = base_reg;
        nts_next       = nts_reg;
        count_next     = count_reg;
        rexp_next      = rexp_reg;
        link_next      = link_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        if (go)
        begin
            pc_next = cond_hit ? uw.target : pc_reg + 5'd1;
            if (uw.count_inc) count_next = count_reg + 3'd1;
            if (uw.count_dec) count_next = count_reg - 3'd1;
            if (uw.next_inc)  nts_next   = seq_next(nts_reg);
            if (uw.base_inc)  base_next  = seq_next(base_reg);
            if (uw.rexp_inc)  rexp_next  = seq_next(rexp_reg);
            if (uw.link_set)  link_next  = 1'b1;
            if (uw.link_clr)  link_next  = 1'b0;
            if (uw.cur_load)
            begin
                cur_next  = base_reg;
                left_next = count_reg;
            end
            if (uw.cur_step)
            begin
                cur_next  = seq_next(cur_reg);
                left_next = left_reg - 3'd1;
            end
            if (uw.emit)
            begin
                out_valid_next          = 1'b1;
                out_next.action         = uw.act;
                out_next.out_seq        = seq_val;
                out_next.out_ack        = uw.ack_lio ? seq_prev(rexp_reg) : '0;
                out_next.last           = (uw.act == ACT_STATUS);
                out_next.network_enable = (uw.act == ACT_STATUS) &&
                                          (count_reg < limit_reg) && link_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_IDLE;
            limit_reg     <= WINDOW_LIMIT_RESET;
            base_reg      <= '0;
            nts_reg       <= '0;
            count_reg     <= '0;
            rexp_reg      <= '0;
            link_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            base_reg      <= base_next;
            nts_reg       <= nts_next;
            count_reg     <= count_next;
            rexp_reg      <= rexp_next;
            link_reg      <= link_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
        end
    end

    // event word, cursor and output word hold payload only
    always_ff @(posedge clk)
    begin
        if (in_fire)
            ev_reg <= in_data;
        cur_reg  <= cur_next;
        left_reg <= left_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[sv/gbn_checker.sv]
// ----------------------------------------------------------------------------
// gbn_checker: port-level checks for the Go-Back-N window control
// Watches the handshakes and the result word framing.
// ----------------------------------------------------------------------------
module gbn_checker
    import gbn_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // an accepted event closes the input until its program has run
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("event accepted while previous event in progress");

    // last marks exactly the status word
    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == (out_data.action == ACT_STATUS)))
        else $error("last flag does not match status word");

    // network enable appears only in the status word
    a_enable_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !out_data.network_enable)
        else $error("network enable outside status word");

endmodule

bind go_back_n_window_control gbn_checker u_gbn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for go_back_n_window_control
// Drives link events through valid/ready with random gaps on both sides,
// predicts the send, ack, deliver, stop-timer and status words of every
// accepted event, and compares each result word field by field.
// ----------------------------------------------------------------------------
module tb;
    import gbn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       set_limit;
        logic [2:0] limit;
        in_item_t   ev;
        int         n_typed;
        out_item_t  typed0;
        out_item_t  typed1;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_wr_en;
    logic [2:0] cfg_wr_data;

    // predicted link state
    logic [2:0] win_limit;
    logic [2:0] win_base;
    logic [2:0] send_next;
    logic [2:0] in_flight;
    logic [2:0] rx_expected;
    logic       link_up;

    out_item_t  step_words[$];
    out_item_t  awaited_words[$];
    stim_row_t  stim_table[$];
    out_item_t  want_word;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         fails;

    go_back_n_window_control dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic in_item_t ev_of(input logic [1:0] cmd, input logic kind,
                                       input logic [2:0] seq, input logic [2:0] ack,
                                       input logic good);
        in_item_t e;
        e.command    = cmd;
        e.frame_kind = kind;
        e.frame_seq  = seq;
        e.cum_ack    = ack;
        e.frame_good = good;
        return e;
    endfunction

    function automatic out_item_t word_of(input logic [2:0] act, input logic [2:0] seq,
                                          input logic [2:0] ack, input logic en,
                                          input logic lst);
        out_item_t w;
        w.action         = act;
        w.out_seq        = seq;
        w.out_ack        = ack;
        w.network_enable = en;
        w.last           = lst;
        return w;
    endfunction

    function automatic void add_row(input logic set, input logic [2:0] lim,
                                    input in_item_t ev, input int n,
                                    input out_item_t w0, input out_item_t w1);
        stim_row_t r;
        r.set_limit = set;
        r.limit     = lim;
        r.ev        = ev;
        r.n_typed   = n;
        r.typed0    = w0;
        r.typed1    = w1;
        stim_table.push_back(r);
    endfunction

    // Work out the words one event causes and advance the link state.
    function automatic void predict_actions(input in_item_t ev);
        logic [2:0] slot;
        logic [2:0] ack_span;
        logic [2:0] win_span;
        int         k;
        step_words.delete();
        unique case (ev.command)
            CMD_PACKET:
            begin
                if (in_flight < win_limit)
                begin
                    in_flight = in_flight + 3'd1;
                    step_words.push_back(word_of(ACT_SEND_DATA, send_next,
                                                 rx_expected - 3'd1, 1'b0, 1'b0));
                    link_up   = 1'b0;
                    send_next = send_next + 3'd1;
                end
            end
            CMD_LINK:
            begin
                link_up = 1'b1;
            end
            CMD_FRAME:
            begin
                if (ev.frame_good)
                begin
                    if (ev.frame_kind == KIND_DATA)
                    begin
                        if (ev.frame_seq == rx_expected)
                        begin
                            step_words.push_back(word_of(ACT_DELIVER, ev.frame_seq,
                                                         3'd0, 1'b0, 1'b0));
                            rx_expected = rx_expected + 3'd1;
                        end
                        step_words.push_back(word_of(ACT_SEND_ACK, 3'd0,
                                                     rx_expected - 3'd1, 1'b0, 1'b0));
                        link_up = 1'b0;
                    end
                    // release every frame up to the cumulative ack, if it lies in the window
                    ack_span = ev.cum_ack - win_base;
                    win_span = send_next - win_base;
                    while (in_flight != 3'd0 && ack_span < win_span)
                    begin
                        in_flight = in_flight - 3'd1;
                        step_words.push_back(word_of(ACT_STOP_TIMER, win_base,
                                                     3'd0, 1'b0, 1'b0));
                        win_base = win_base + 3'd1;
                        ack_span = ev.cum_ack - win_base;
                        win_span = send_next - win_base;
                    end
                end
            end
            default:
            begin
                slot = win_base;
                for (k = 0; k < in_flight; k++)
                begin
                    step_words.push_back(word_of(ACT_SEND_DATA, slot,
                                                 rx_expected - 3'd1, 1'b0, 1'b0));
                    link_up = 1'b0;
                    slot = slot + 3'd1;
                end
            end
        endcase
        step_words.push_back(word_of(ACT_STATUS, 3'd0, 3'd0,
                                     (in_flight < win_limit) && link_up, 1'b1));
    endfunction

    // Mostly well-formed events: frames carry the awaited sequence and an ack
    // inside the window; the rest is random noise.
    function automatic in_item_t random_event();
        in_item_t   e;
        logic [2:0] off;
        int         pick;
        e = in_item_t'(10'($urandom_range(0, 1023)));
        pick = $urandom_range(0, 99);
        if (pick < 30)
            e.command = CMD_PACKET;
        else if (pick < 48)
            e.command = CMD_LINK;
        else if (pick < 86)
            e.command = CMD_FRAME;
        else
            e.command = CMD_TIMEOUT;
        if (e.command == CMD_FRAME)
        begin
            e.frame_good = ($urandom_range(0, 99) < 88);
            if ($urandom_range(0, 99) < 60)
                e.frame_seq = rx_expected;
            if (in_flight != 3'd0 && $urandom_range(0, 99) < 65)
            begin
                off = 3'($urandom_range(0, in_flight - 1));
                e.cum_ack = win_base + off;
            end
        end
        return e;
    endfunction

    task automatic set_idle(input int mode);
        unique case (mode)
            0:       begin send_idle_pct = 18; recv_idle_pct = 73; end
            1:       begin send_idle_pct = 73; recv_idle_pct = 18; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
    endtask

    // Hold off until every awaited word is back, then write the register.
    task automatic set_window_limit(input logic [2:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        win_limit = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_event(input in_item_t ev, input int n_typed,
                              input out_item_t t0, input out_item_t t1);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_actions(ev);
        if (n_typed == 0)
        begin
            foreach (step_words[j])
                awaited_words.push_back(step_words[j]);
        end
        else
        begin
            awaited_words.push_back(t0);
            if (n_typed > 1)
                awaited_words.push_back(t1);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_words.size() == 0)
            begin
                $error("unexpected word: action %0d seq %0d ack %0d",
                       out_data.action, out_data.out_seq, out_data.out_ack);
                fails++;
            end
            else
            begin
                want_word = awaited_words.pop_front();
                if (out_data.action !== want_word.action)
                begin
                    $error("action: expected %0d, got %0d", want_word.action,
                           out_data.action);
                    fails++;
                end
                if (out_data.out_seq !== want_word.out_seq)
                begin
                    $error("out_seq: expected %0d, got %0d", want_word.out_seq,
                           out_data.out_seq);
                    fails++;
                end
                if (out_data.out_ack !== want_word.out_ack)
                begin
                    $error("out_ack: expected %0d, got %0d", want_word.out_ack,
                           out_data.out_ack);
                    fails++;
                end
                if (out_data.network_enable !== want_word.network_enable)
                begin
                    $error("network_enable: expected %0d, got %0d",
                           want_word.network_enable, out_data.network_enable);
                    fails++;
                end
                if (out_data.last !== want_word.last)
                begin
                    $error("last: expected %0d, got %0d", want_word.last, out_data.last);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        out_item_t  sent0;
        out_item_t  idle_off;
        out_item_t  idle_on;
        logic [2:0] seg_limit;
        int         seg;
        int         n;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 3'd0;
        fails       = 0;
        win_limit   = WINDOW_LIMIT_RESET;
        win_base    = 3'd0;
        send_next   = 3'd0;
        in_flight   = 3'd0;
        rx_expected = 3'd0;
        link_up     = 1'b0;
        set_idle(2);

        sent0    = word_of(ACT_SEND_DATA, 3'd0, 3'd7, 1'b0, 1'b0);
        idle_off = word_of(ACT_STATUS, 3'd0, 3'd0, 1'b0, 1'b1);
        idle_on  = word_of(ACT_STATUS, 3'd0, 3'd0, 1'b1, 1'b1);

        add_row(1'b0, 3'd0, ev_of(CMD_PACKET, 1'b0, 3'd0, 3'd0, 1'b0), 2, sent0, idle_off);
        add_row(1'b0, 3'd0, ev_of(CMD_LINK, 1'b0, 3'd0, 3'd0, 1'b0), 1, idle_on, '0);
        add_row(1'b0, 3'd0, ev_of(CMD_TIMEOUT, 1'b0, 3'd0, 3'd0, 1'b0), 2, sent0, idle_off);
        // bad frame: dropped whatever it carries
        add_row(1'b0, 3'd0, ev_of(CMD_FRAME, KIND_ACK, 3'd7, 3'd7, 1'b0), 1, idle_off, '0);
        add_row(1'b0, 3'd0, ev_of(CMD_LINK, 1'b1, 3'd7, 3'd7, 1'b1), 0, '0, '0);
        add_row(1'b0, 3'd0, ev_of(CMD_FRAME, KIND_DATA, 3'd0, 3'd0, 1'b1), 0, '0, '0);
        // ack with nothing outstanding
        add_row(1'b0, 3'd0, ev_of(CMD_FRAME, KIND_ACK, 3'd0, 3'd5, 1'b1), 0, '0, '0);
        for (n = 0; n < 7; n++)
            add_row(1'b0, 3'd0, ev_of(CMD_PACKET, 1'b0, 3'd0, 3'd0, 1'b0), 0, '0, '0);
        // full window
        add_row(1'b0, 3'd0, ev_of(CMD_PACKET, 1'b1, 3'd7, 3'd7, 1'b1), 1, idle_off, '0);
        // out-of-order data, ack outside the window
        add_row(1'b0, 3'd0, ev_of(CMD_FRAME, KIND_DATA, 3'd5, 3'd0, 1'b1), 0, '0, '0);
        add_row(1'b0, 3'd0, ev_of(CMD_TIMEOUT, 1'b0, 3'd0, 3'd0, 1'b0), 0, '0, '0);
        // in-order data releasing the whole window: the longest event
        add_row(1'b0, 3'd0, ev_of(CMD_FRAME, KIND_DATA, 3'd1, 3'd7, 1'b1), 0, '0, '0);
        add_row(1'b0, 3'd0, ev_of(CMD_TIMEOUT, 1'b1, 3'd7, 3'd7, 1'b1), 1, idle_off, '0);
        add_row(1'b0, 3'd0, ev_of(CMD_LINK, 1'b0, 3'd0, 3'd0, 1'b0), 1, idle_on, '0);
        // zero limit: no packet gets in
        add_row(1'b1, 3'd0, ev_of(CMD_PACKET, 1'b0, 3'd0, 3'd0, 1'b0), 1, idle_off, '0);
        add_row(1'b1, 3'd1, ev_of(CMD_PACKET, 1'b0, 3'd0, 3'd0, 1'b0), 0, '0, '0);
        add_row(1'b0, 3'd0, ev_of(CMD_PACKET, 1'b0, 3'd0, 3'd0, 1'b0), 1, idle_off, '0);
        add_row(1'b0, 3'd0, ev_of(CMD_FRAME, KIND_ACK, 3'd0, 3'd0, 1'b1), 0, '0, '0);
        add_row(1'b0, 3'd0, ev_of(CMD_LINK, 1'b0, 3'd0, 3'd0, 1'b0), 0, '0, '0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].set_limit)
                set_window_limit(stim_table[i].limit);
            push_event(stim_table[i].ev, stim_table[i].n_typed,
                       stim_table[i].typed0, stim_table[i].typed1);
        end

        for (seg = 0; seg < 6; seg++)
        begin
            unique case (seg)
                0:       seg_limit = 3'd7;
                1:       seg_limit = 3'd1;
                3:       seg_limit = 3'd0;
                5:       seg_limit = 3'd7;
                default: seg_limit = 3'($urandom_range(2, 6));
            endcase
            set_window_limit(seg_limit);
            set_idle(seg / 2);
            for (n = 0; n < 31; n++)
                push_event(random_event(), 0, '0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[files.f]
sv/gbn_pkg.sv
sv/go_back_n_window_control.sv
sv/gbn_checker.sv
test/tb.sv
